// ----- hdl/mma_pkg.sv -----
package mma_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned WIDE_W = 64;

  localparam int unsigned REQ_W = 4;
  localparam int unsigned OPND_W = 31;

  localparam logic [REQ_W-1:0] REQ_CONVERT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_ADD     = 4'd1;
  localparam logic [REQ_W-1:0] REQ_SUB     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_MUL     = 4'd3;
  localparam logic [REQ_W-1:0] REQ_POW     = 4'd4;
  localparam logic [REQ_W-1:0] REQ_INV     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_DIVIDE  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_GET     = 4'd7;
  localparam logic [REQ_W-1:0] REQ_EQUAL   = 4'd8;
  localparam logic [REQ_W-1:0] REQ_NEGATE  = 4'd9;

  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_NEG_INV = 2'd1;
  localparam logic [1:0] CFG_R_SQ    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DWAIT,
    ST_MSTART,
    ST_MWAIT,
    ST_POW,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_SINGLE,
    PH_GET,
    PH_ONE,
    PH_ACC,
    PH_SQ
  } phase_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] res;
  } mul_rsp_t;

endpackage

// ----- hdl/mma_divider.sv -----
module mma_divider #(
  parameter int unsigned MODULUS_BITS = 30
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [mma_pkg::WIDE_W-1:0] dividend,
  input  logic [MODULUS_BITS-1:0] divisor,
  output logic                    done,
  output logic [MODULUS_BITS-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(mma_pkg::WIDE_W + 1);

  logic                       busy_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [mma_pkg::WIDE_W-1:0] dvd_r;
  logic [MODULUS_BITS-1:0]    rem_r;
  logic                       done_r;
  logic [MODULUS_BITS:0]      trial;
  logic [MODULUS_BITS:0]      rem_nxt;

  // One restoring step a cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_r, dvd_r[mma_pkg::WIDE_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = trial - {1'b0, divisor};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(mma_pkg::WIDE_W);
        dvd_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt[MODULUS_BITS-1:0];
        dvd_r <= {dvd_r[mma_pkg::WIDE_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- hdl/mma_mont_mul.sv -----
module mma_mont_mul #(
  parameter int unsigned MODULUS_BITS = 30
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mma_pkg::mul_req_t           req,
  input  logic [mma_pkg::WORD_W-1:0]  neg_inv,
  input  logic [MODULUS_BITS-1:0]     modulus,
  output mma_pkg::mul_rsp_t           rsp
);

  localparam int unsigned W = mma_pkg::WORD_W;

  logic [1:0]     step_r;
  logic           busy_r;
  logic           done_r;
  logic [2*W-1:0] p_r;
  logic [W-1:0]   q_r;
  logic [2*W-1:0] t_r;
  logic [W-1:0]   res_r;
  logic [W-1:0]   mul_a;
  logic [W-1:0]   mul_b;
  logic [2*W-1:0] prod;
  logic [2*W:0]   sum;

  // Single shared 32x32 multiplier: product, then q, then q * modulus.
  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = p_r[W-1:0];
        mul_b = neg_inv;
      end
      2'd1: begin
        mul_a = q_r;
        mul_b = {{(W-MODULUS_BITS){1'b0}}, modulus};
      end
      default: begin
        mul_a = req.x;
        mul_b = req.y;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = {1'b0, p_r} + {1'b0, t_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd3;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        p_r    <= prod;
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        case (step_r)
          2'd0: begin
            q_r    <= prod[W-1:0];
            step_r <= 2'd1;
          end
          2'd1: begin
            t_r    <= prod;
            step_r <= 2'd2;
          end
          default: begin
            res_r  <= sum[2*W-1:W];
            busy_r <= 1'b0;
            done_r <= 1'b1;
            step_r <= 2'd3;
          end
        endcase
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ----- hdl/montgomery_modular_alu_unit.sv -----
// Montgomery modular ALU, R = 2^32, one request in flight; paths from input to out_tvalid:
// add, sub, negate, equal, unknown go direct to output; multiply and get: one multiply;
// convert runs a 64-step remainder, then a multiply. Power/inverse/divide: a multiply for the
// Montgomery one, then per exponent bit: a decision step, a multiply if set, and a square.
// Divide adds a final multiply; all use one multiplier. A new request waits for out_tready.
// Reset (rst_n low, synchronous): idle, modulus 1, mont_neg_inv all ones, r_squared 0.
module montgomery_modular_alu_unit #(
  parameter int unsigned MODULUS_BITS = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  // req_type[3:0], operand_a[34:4], operand_b[65:35], signed_value[129:66],
  // exponent[193:130], zero pad above
  input  logic [199:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // result_value[30:0], equal_flag[31]
  output logic [31:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned W  = mma_pkg::WORD_W;
  localparam int unsigned MB = MODULUS_BITS;

  mma_pkg::state_t state_r, state_nxt;
  mma_pkg::phase_t phase_r;

  // Configuration registers
  logic [MB-1:0] mod_r;
  logic [W-1:0]  nin_r;
  logic [MB-1:0] r2_r;

  // Request context
  logic [mma_pkg::OPND_W-1:0] a_r;
  logic [mma_pkg::WIDE_W-1:0] mag_r;
  logic                       neg_r;
  logic [mma_pkg::WIDE_W-1:0] exp_r;
  logic [W-1:0]               acc_r;
  logic [W-1:0]               sq_r;
  logic                       divide_r;
  logic [W-1:0]               mx_r;
  logic [W-1:0]               my_r;
  logic [31:0]                out_data_r;

  // Input field views
  logic [mma_pkg::REQ_W-1:0]  in_req;
  logic [mma_pkg::OPND_W-1:0] in_a;
  logic [mma_pkg::OPND_W-1:0] in_b;
  logic [mma_pkg::WIDE_W-1:0] in_sv;
  logic [mma_pkg::WIDE_W-1:0] in_exp;
  logic                       in_xfer;

  assign in_req  = in_tdata[3:0];
  assign in_a    = in_tdata[34:4];
  assign in_b    = in_tdata[65:35];
  assign in_sv   = in_tdata[129:66];
  assign in_exp  = in_tdata[193:130];
  assign in_xfer = in_tvalid && in_tready;

  logic [W-1:0] mod_w;
  logic [W-1:0] mod2_w;
  logic [W-1:0] r2_w;
  logic [W-1:0] one_t;
  logic [W-1:0] fermat_e;
  logic [W-1:0] a_w;
  logic [W-1:0] b_w;
  logic [W-1:0] pa;
  logic [W-1:0] pb;
  logic [W-1:0] add_raw;
  logic [W-1:0] sub_raw;
  logic [W-1:0] neg_raw;
  logic [W-1:0] quick_res;
  logic         quick_eq;

  assign mod_w    = {{(W-MB){1'b0}}, mod_r};
  assign mod2_w   = {mod_w[W-2:0], 1'b0};
  assign r2_w     = {{(W-MB){1'b0}}, r2_r};
  assign fermat_e = mod_w - W'(2);
  assign a_w      = {1'b0, in_a};
  assign b_w      = {1'b0, in_b};

  // Pre-reduction value for the Montgomery form of one: modulus + (1 mod modulus).
  always_comb begin
    if (mod_r == '0) begin
      one_t = '0;
    end else if (mod_w == W'(1)) begin
      one_t = W'(1);
    end else begin
      one_t = mod_w + W'(1);
    end
  end

  // Quick ops (add, sub, negate): wrap, then add 2*modulus back when bit 31 is set.
  assign add_raw = a_w + b_w - mod2_w;
  assign sub_raw = a_w - b_w;
  assign neg_raw = W'(0) - a_w;
  assign pa      = (a_w >= mod_w) ? a_w - mod_w : a_w;
  assign pb      = (b_w >= mod_w) ? b_w - mod_w : b_w;

  always_comb begin
    quick_res = '0;
    quick_eq  = 1'b0;
    case (in_req)
      mma_pkg::REQ_ADD:    quick_res = add_raw[W-1] ? add_raw + mod2_w : add_raw;
      mma_pkg::REQ_SUB:    quick_res = sub_raw[W-1] ? sub_raw + mod2_w : sub_raw;
      mma_pkg::REQ_NEGATE: quick_res = neg_raw[W-1] ? neg_raw + mod2_w : neg_raw;
      mma_pkg::REQ_EQUAL:  quick_eq  = (pa == pb);
      default: begin
        quick_res = '0;
        quick_eq  = 1'b0;
      end
    endcase
  end

  // Serial remainder for convert
  logic          div_start;
  logic          div_done;
  logic [MB-1:0] div_rem;

  mma_divider #(
    .MODULUS_BITS(MB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(mag_r),
    .divisor (mod_r),
    .done    (div_done),
    .rem     (div_rem)
  );

  logic [W-1:0] rem_w;
  logic [W-1:0] conv_t;

  // A zero modulus leaves the divider's remainder meaningless; force zero.
  assign rem_w  = (mod_r == '0) ? '0 : {{(W-MB){1'b0}}, div_rem};
  assign conv_t = neg_r ? mod_w - rem_w : mod_w + rem_w;

  // Shared Montgomery multiplier
  mma_pkg::mul_req_t mul_req;
  mma_pkg::mul_rsp_t mul_rsp;
  logic [W-1:0]      get_res;

  mma_mont_mul #(
    .MODULUS_BITS(MB)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mul_req),
    .neg_inv(nin_r),
    .modulus(mod_r),
    .rsp    (mul_rsp)
  );

  assign get_res = (mul_rsp.res >= mod_w) ? mul_rsp.res - mod_w : mul_rsp.res;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mma_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_req)
            mma_pkg::REQ_CONVERT: state_nxt = mma_pkg::ST_DSTART;
            mma_pkg::REQ_MUL,
            mma_pkg::REQ_POW,
            mma_pkg::REQ_INV,
            mma_pkg::REQ_DIVIDE,
            mma_pkg::REQ_GET:     state_nxt = mma_pkg::ST_MSTART;
            default:              state_nxt = mma_pkg::ST_OUT;
          endcase
        end
      end
      mma_pkg::ST_DSTART: state_nxt = mma_pkg::ST_DWAIT;
      mma_pkg::ST_DWAIT: begin
        if (div_done) begin
          state_nxt = mma_pkg::ST_MSTART;
        end
      end
      mma_pkg::ST_MSTART: state_nxt = mma_pkg::ST_MWAIT;
      mma_pkg::ST_MWAIT: begin
        if (mul_rsp.done) begin
          case (phase_r)
            mma_pkg::PH_SINGLE,
            mma_pkg::PH_GET: state_nxt = mma_pkg::ST_OUT;
            mma_pkg::PH_ACC: state_nxt = mma_pkg::ST_MSTART;
            default:         state_nxt = mma_pkg::ST_POW;
          endcase
        end
      end
      mma_pkg::ST_POW: begin
        if (exp_r == '0 && !divide_r) begin
          state_nxt = mma_pkg::ST_OUT;
        end else begin
          state_nxt = mma_pkg::ST_MSTART;
        end
      end
      mma_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = mma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mma_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    div_start     = 1'b0;
    mul_req.start = 1'b0;
    mul_req.x     = mx_r;
    mul_req.y     = my_r;
    case (state_r)
      mma_pkg::ST_IDLE:   in_tready     = 1'b1;
      mma_pkg::ST_DSTART: div_start     = 1'b1;
      mma_pkg::ST_MSTART: mul_req.start = 1'b1;
      mma_pkg::ST_OUT:    out_tvalid    = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign out_tdata = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mma_pkg::ST_IDLE;
      mod_r   <= MB'(1);
      nin_r   <= '1;
      r2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mma_pkg::CFG_MODULUS: mod_r <= cfg_data[MB-1:0];
          mma_pkg::CFG_NEG_INV: nin_r <= cfg_data;
          mma_pkg::CFG_R_SQ:    r2_r  <= cfg_data[MB-1:0];
          default:              nin_r <= nin_r;
        endcase
      end
    end
  end

  // Datapath registers: no reset needed, state gates every use.
  always_ff @(posedge clk) begin
    case (state_r)
      mma_pkg::ST_IDLE: begin
        if (in_xfer) begin
          a_r      <= in_a;
          neg_r    <= in_sv[mma_pkg::WIDE_W-1];
          mag_r    <= in_sv[mma_pkg::WIDE_W-1] ? (mma_pkg::WIDE_W'(0) - in_sv) : in_sv;
          divide_r <= (in_req == mma_pkg::REQ_DIVIDE);
          sq_r     <= (in_req == mma_pkg::REQ_DIVIDE) ? b_w : a_w;
          exp_r    <= (in_req == mma_pkg::REQ_POW) ? in_exp
                                                   : {{(mma_pkg::WIDE_W-W){1'b0}}, fermat_e};
          out_data_r <= {quick_eq, quick_res[mma_pkg::OPND_W-1:0]};
          case (in_req)
            mma_pkg::REQ_MUL: begin
              mx_r    <= a_w;
              my_r    <= b_w;
              phase_r <= mma_pkg::PH_SINGLE;
            end
            mma_pkg::REQ_GET: begin
              mx_r    <= a_w;
              my_r    <= W'(1);
              phase_r <= mma_pkg::PH_GET;
            end
            default: begin
              // power, inverse, divide: start from the Montgomery form of one
              mx_r    <= one_t;
              my_r    <= r2_w;
              phase_r <= mma_pkg::PH_ONE;
            end
          endcase
        end
      end
      mma_pkg::ST_DWAIT: begin
        if (div_done) begin
          mx_r    <= conv_t;
          my_r    <= r2_w;
          phase_r <= mma_pkg::PH_SINGLE;
        end
      end
      mma_pkg::ST_MWAIT: begin
        if (mul_rsp.done) begin
          case (phase_r)
            mma_pkg::PH_SINGLE: out_data_r <= {1'b0, mul_rsp.res[mma_pkg::OPND_W-1:0]};
            mma_pkg::PH_GET:    out_data_r <= {1'b0, get_res[mma_pkg::OPND_W-1:0]};
            mma_pkg::PH_ONE:    acc_r <= mul_rsp.res;
            mma_pkg::PH_ACC: begin
              acc_r   <= mul_rsp.res;
              mx_r    <= sq_r;
              my_r    <= sq_r;
              phase_r <= mma_pkg::PH_SQ;
            end
            default: begin
              sq_r  <= mul_rsp.res;
              exp_r <= {1'b0, exp_r[mma_pkg::WIDE_W-1:1]};
            end
          endcase
        end
      end
      mma_pkg::ST_POW: begin
        if (exp_r == '0) begin
          // divide finishes with operand_a times the inverse
          mx_r       <= {1'b0, a_r};
          my_r       <= acc_r;
          phase_r    <= mma_pkg::PH_SINGLE;
          out_data_r <= {1'b0, acc_r[mma_pkg::OPND_W-1:0]};
        end else if (exp_r[0]) begin
          mx_r    <= acc_r;
          my_r    <= sq_r;
          phase_r <= mma_pkg::PH_ACC;
        end else begin
          mx_r    <= sq_r;
          my_r    <= sq_r;
          phase_r <= mma_pkg::PH_SQ;
        end
      end
      default: begin
        mx_r <= mx_r;
      end
    endcase
  end

endmodule

// ----- hdl/mma_checker.sv -----
module mma_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [31:0]  out_tdata,
  input logic         out_tvalid,
  input logic         out_tready
);

  // Hold a stalled result steady.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // One request at a time: a transfer drops in_tready.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // Equal results carry a zero value field.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31] |-> out_tdata[30:0] == 31'd0)
    else $error("equal flag with nonzero value");

endmodule

bind montgomery_modular_alu_unit mma_checker u_mma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tdata (out_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);

// ----- verif/tb_montgomery_modular_alu_unit.sv -----
`timescale 1ns / 1ps

module tb_montgomery_modular_alu_unit;

  localparam logic [31:0] MOD_MASK = 32'h3FFF_FFFF;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic        eq;
    logic [30:0] value;
  } alu_result_t;

  typedef struct {
    logic [mma_pkg::REQ_W-1:0]  req;
    logic [mma_pkg::OPND_W-1:0] a;
    logic [mma_pkg::OPND_W-1:0] b;
    logic [63:0]                sv;
    logic [63:0]                ex;
  } alu_req_t;

  logic         clk;
  logic         rst_n;
  logic [199:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;

  // Predictor's copy of the configuration registers.
  logic [31:0] pm_modulus;
  logic [31:0] pm_neg_inv;
  logic [31:0] pm_r_sq;

  alu_result_t pending_results[$];
  int          mismatches;
  longint unsigned cycle_count;
  int          gap_max;
  int          rx_hold_cycles;

  montgomery_modular_alu_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Modular arithmetic predictor (R = 2^32, all sums wrap like the hardware)
  // ---------------------------------------------------------------------
  function automatic logic [31:0] redc(input logic [63:0] x);
    logic [31:0] q;
    logic [63:0] s;
    q = x[31:0] * pm_neg_inv;
    s = x + {32'b0, q} * {32'b0, pm_modulus};
    return s[63:32];
  endfunction

  function automatic logic [31:0] enter_mont(input logic [63:0] raw);
    logic [63:0] mag;
    logic [63:0] rem;
    logic [63:0] t;
    mag = raw[63] ? (64'd0 - raw) : raw;
    rem = (pm_modulus != 0) ? (mag % {32'b0, pm_modulus}) : 64'd0;
    t = raw[63] ? ({32'b0, pm_modulus} - rem) : ({32'b0, pm_modulus} + rem);
    return redc(t * {32'b0, pm_r_sq});
  endfunction

  function automatic logic [31:0] wrap_fix(input logic [31:0] v);
    return v[31] ? v + 2 * pm_modulus : v;
  endfunction

  function automatic logic [31:0] mont_power(input logic [31:0] base, input logic [63:0] ex);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = enter_mont(64'd1);
    sq = base;
    for (int i = 0; i < 64; i++) begin
      if (ex[i]) acc = redc({32'b0, acc} * {32'b0, sq});
      sq = redc({32'b0, sq} * {32'b0, sq});
    end
    return acc;
  endfunction

  function automatic logic [31:0] fermat_inv(input logic [31:0] v);
    logic [31:0] e32;
    e32 = pm_modulus - 32'd2;
    return mont_power(v, {32'b0, e32});
  endfunction

  function automatic logic [31:0] fold_once(input logic [31:0] v);
    return (v >= pm_modulus) ? v - pm_modulus : v;
  endfunction

  function automatic alu_result_t compute_result(input alu_req_t r);
    alu_result_t res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    a = {1'b0, r.a};
    b = {1'b0, r.b};
    v = 32'd0;
    res.eq = 1'b0;
    case (r.req)
      mma_pkg::REQ_CONVERT: v = enter_mont(r.sv);
      mma_pkg::REQ_ADD:     v = wrap_fix(a + b - 2 * pm_modulus);
      mma_pkg::REQ_SUB:     v = wrap_fix(a - b);
      mma_pkg::REQ_MUL:     v = redc({32'b0, a} * {32'b0, b});
      mma_pkg::REQ_POW:     v = mont_power(a, r.ex);
      mma_pkg::REQ_INV:     v = fermat_inv(a);
      mma_pkg::REQ_DIVIDE:  v = redc({32'b0, a} * {32'b0, fermat_inv(b)});
      mma_pkg::REQ_GET:     v = fold_once(redc({32'b0, a}));
      mma_pkg::REQ_EQUAL:   res.eq = (fold_once(a) == fold_once(b));
      mma_pkg::REQ_NEGATE:  v = wrap_fix(32'd0 - a);
      default:              v = 32'd0;
    endcase
    res.value = v[30:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus plumbing
  // ---------------------------------------------------------------------
  // Present one request after a random gap; hold until the transfer.
  task automatic send_req(input alu_req_t r);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, r.ex, r.sv, r.b, r.a, r.req};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(compute_result(r));
  endtask

  // Drop valid and wait until every outstanding result has been checked.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mma_pkg::CFG_MODULUS: pm_modulus = data & MOD_MASK;
      mma_pkg::CFG_NEG_INV: pm_neg_inv = data;
      mma_pkg::CFG_R_SQ:    pm_r_sq = data & MOD_MASK;
      default: ;
    endcase
  endtask

  // Program a consistent modulus: -m^-1 mod 2^32 and 2^64 mod m.
  task automatic program_modulus(input logic [31:0] m);
    logic [31:0] inv;
    logic [64:0] r2;
    inv = m;
    repeat (5) inv = inv * (32'd2 - m * inv);
    r2 = (m != 0) ? (65'h1_0000_0000_0000_0000 % {33'b0, m}) : 65'd0;
    wait_idle();
    write_reg(mma_pkg::CFG_MODULUS, m);
    write_reg(mma_pkg::CFG_NEG_INV, 32'd0 - inv);
    write_reg(mma_pkg::CFG_R_SQ, r2[31:0]);
    cfg_valid <= 1'b0;
  endtask

  function automatic alu_req_t make_req(input logic [mma_pkg::REQ_W-1:0] req,
                                        input logic [30:0] a, input logic [30:0] b,
                                        input logic [63:0] sv, input logic [63:0] ex);
    alu_req_t r;
    r.req = req;
    r.a = a;
    r.b = b;
    r.sv = sv;
    r.ex = ex;
    return r;
  endfunction

  function automatic logic [30:0] rand_operand();
    logic [31:0] lim;
    lim = 2 * pm_modulus;
    if ($urandom_range(0, 99) < 85 && lim != 0) return 31'($urandom % lim);
    return 31'($urandom);
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.req = (sel < 5) ? mma_pkg::REQ_W'($urandom_range(10, 15))
                      : mma_pkg::REQ_W'($urandom_range(0, 9));
    r.a = rand_operand();
    r.b = ($urandom_range(0, 7) == 0) ? r.a : rand_operand();
    if (r.req == mma_pkg::REQ_EQUAL && $urandom_range(0, 2) == 0) r.b = 31'(r.a + pm_modulus);
    r.sv = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) r.sv = 64'(signed'($urandom_range(0, 64)) - 32);
    // Exponents get a random bit length by shifting out up to 63 top bits.
    r.ex = {$urandom, $urandom} >> $urandom_range(0, 63);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: compare each transfer with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[30:0] != want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   out_tdata[30:0]);
          mismatches++;
        end
        if (out_tdata[31] != want.eq) begin
          $display("%0t: equal_flag expected %b actual %b", $time, want.eq, out_tdata[31]);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random stall per result, plus an optional long hold-off.
  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("montgomery_modular_alu_unit regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Reset values: modulus 1, all-ones inverse, zero r_squared.
  task automatic test_reset_defaults();
    for (int op = 0; op < 10; op++)
      send_req(make_req(mma_pkg::REQ_W'(op), 31'h7FFF_FFFF, 31'd1, 64'h8000_0000_0000_0000,
                        64'hFFFF_FFFF_FFFF_FFFF));
  endtask

  // Directed corners on a production-size prime.
  task automatic test_directed_corners();
    logic [30:0] m;
    logic [30:0] top;
    program_modulus(32'd998244353);
    m = pm_modulus[30:0];
    top = 31'(2 * m - 1);
    send_req(make_req(mma_pkg::REQ_CONVERT, 31'd0, 31'd0, 64'h8000_0000_0000_0000, 64'd0));
    send_req(make_req(mma_pkg::REQ_CONVERT, 31'd0, 31'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0));
    send_req(make_req(mma_pkg::REQ_CONVERT, 31'd0, 31'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0));
    send_req(make_req(mma_pkg::REQ_CONVERT, 31'd0, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_ADD, top, top, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_ADD, 31'd0, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_SUB, 31'd0, top, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_SUB, 31'h7FFF_FFFF, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_MUL, top, top, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_MUL, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_POW, 31'd12345, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_POW, 31'd12345, 31'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_req(make_req(mma_pkg::REQ_INV, 31'd777, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_INV, 31'd0, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_DIVIDE, 31'd4242, 31'd999, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_GET, top, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_GET, 31'd0, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_EQUAL, 31'd5, 31'(m + 31'd5), 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_EQUAL, 31'd5, 31'd6, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_NEGATE, 31'd0, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_NEGATE, 31'h7FFF_FFFF, 31'd0, 64'd0, 64'd0));
    send_req(make_req(mma_pkg::REQ_W'(15), 31'h7FFF_FFFF, 31'h7FFF_FFFF, 64'd0, 64'd0));
  endtask

  // Random requests under the current modulus.
  task automatic test_random_ops(input int count);
    for (int i = 0; i < count; i++) begin
      // Every 40 requests, pick at random bursts with or without idling.
      if (i % 40 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      send_req(rand_req());
    end
  endtask

  // Zero modulus with raw register values; high modulus bits are masked off.
  task automatic test_zero_modulus();
    wait_idle();
    write_reg(mma_pkg::CFG_MODULUS, 32'hC000_0000);
    write_reg(mma_pkg::CFG_NEG_INV, $urandom);
    write_reg(mma_pkg::CFG_R_SQ, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    test_random_ops(60);
  endtask

  // Hold the receiver off while the sender keeps offering requests.
  task automatic test_backpressure();
    wait_idle();
    rx_hold_cycles = 400;
    gap_max = 0;
    for (int i = 0; i < 8; i++)
      send_req(make_req(mma_pkg::REQ_W'($urandom_range(1, 3)), rand_operand(), rand_operand(),
                        64'd0, 64'd0));
    gap_max = 6;
  endtask

  // Pause the sender until every result is back, then resume.
  task automatic test_sender_pause();
    test_random_ops(20);
    wait_idle();
    test_random_ops(20);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= mma_pkg::CFG_MODULUS;
    cfg_data <= '0;
    pm_modulus = 32'd1;
    pm_neg_inv = 32'hFFFF_FFFF;
    pm_r_sq = 32'd0;
    mismatches = 0;
    gap_max = 6;
    rx_hold_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_corners();
    test_random_ops(110);
    test_backpressure();
    test_sender_pause();
    program_modulus(32'd1073741823);
    test_random_ops(110);
    program_modulus(32'd3);
    test_random_ops(100);
    program_modulus(32'd1);
    test_random_ops(60);
    program_modulus({2'b0, 29'($urandom_range(0, 32'h1FFF_FFFF)), 1'b1});
    test_random_ops(100);
    test_zero_modulus();
    program_modulus({24'b0, 7'($urandom_range(1, 32'h7F)), 1'b1});
    test_random_ops(100);

    wait_idle();
    if (mismatches == 0) begin
      $display("montgomery_modular_alu_unit regression: pass");
    end else begin
      $display("montgomery_modular_alu_unit regression: fail");
    end
    $finish;
  end

endmodule
